[hdl/hft_pkg.sv]
// Package with the item types, status codes and FNV-1a step shared by the flag table.
`timescale 1ns / 1ps

package hft_pkg;

    // FNV-1a 32-bit constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Status codes reported with each result item.
    localparam logic [2:0] ST_GET_HIT  = 3'd0;
    localparam logic [2:0] ST_GET_MISS = 3'd1;
    localparam logic [2:0] ST_SET_UPD  = 3'd2;
    localparam logic [2:0] ST_SET_INS  = 3'd3;
    localparam logic [2:0] ST_SET_FULL = 3'd4;

    // Request type on the last byte of a name.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // One input item: a single byte of a flag name.
    typedef struct packed {
        logic       req_type;
        logic [7:0] name_byte;
        logic       name_last;
        logic       set_value;
    } hft_item_t;

    // One result item, produced for the last byte of a name.
    typedef struct packed {
        logic        flag_value;
        logic [2:0]  op_status;
        logic [31:0] name_hash;
    } hft_result_t;

    // Write controls for the entry memories.
    typedef struct packed {
        logic        key_we;
        logic        val_we;
        logic [31:0] key;
        logic        val;
    } hft_wr_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        HFT_IDLE,
        HFT_SCAN,
        HFT_RESP
    } hft_state_t;

    // One FNV-1a step: xor in the byte, then multiply by the prime modulo 2^32.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

[hdl/hashed_flag_table_core.sv]
// Top level of the hashed flag table: FNV-1a name hashing and a sequential table walk.
`timescale 1ns / 1ps
//
// A flag name arrives one byte per item on the item port. An item is taken at a
// rising edge where start is high and busy is low. Bytes that are not marked
// last only fold into the running FNV-1a hash and are taken one per cycle.
// The byte marked last starts a request against the entry table: the table
// memory is read one entry per cycle from index 0 upward, and the first entry
// whose key matches the hash wins. Busy stays high through the walk and the
// response state; the walk ends at a hit or after the last stored entry, and
// an empty table goes straight to the response. The set or update is written
// back in the response state, the last busy cycle, with done high for one
// cycle with the result item. The key read, one entry per cycle, paces the walk.
// The receiver cannot stall: the result is valid only in the cycle done is high.
// Reset clears the entry count and returns the running hash to the offset basis.
// Entries beyond the count are never read, so the memories need no clearing.
//
module hashed_flag_table_core
    import hft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hft_item_t   item,
    output logic        done,
    output hft_result_t result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(TABLE_ENTRIES);

    hft_state_t       state_reg, state_next;
    logic [31:0]      hash_reg, hash_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;
    logic [31:0]      key_reg, key_next;
    logic             type_reg, type_next;
    logic             setval_reg, setval_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_val_reg, hit_val_next;

    logic        accept;
    logic [31:0] step_hash;
    logic        issue;
    logic        match;
    logic        has_room;
    logic [31:0] rd_key;
    logic        rd_val;
    logic [IDX_W-1:0] wr_addr;
    hft_wr_t     wr;

    assign accept    = start && (state_reg == HFT_IDLE);
    assign step_hash = fnv_step(hash_reg, item.name_byte);
    assign issue     = (state_reg == HFT_SCAN) && (addr_reg < count_reg);
    assign match     = cmp_valid_reg && (rd_key == key_reg);
    assign has_room  = count_reg < MAX_COUNT;

    // Entry memories.
    hft_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W(IDX_W)
    ) u_table (
        .clk(clk),
        .rd_en(issue),
        .rd_addr(addr_reg[IDX_W-1:0]),
        .rd_key(rd_key),
        .rd_val(rd_val),
        .wr_addr(wr_addr),
        .wr(wr)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            HFT_IDLE:
            begin
                if (accept && item.name_last)
                begin
                    state_next = (count_reg == '0) ? HFT_RESP : HFT_SCAN;
                end
            end
            HFT_SCAN:
            begin
                if (match || !issue)
                begin
                    state_next = HFT_RESP;
                end
            end
            HFT_RESP:
            begin
                state_next = HFT_IDLE;
            end
            default:
            begin
                state_next = HFT_IDLE;
            end
        endcase
    end

    // Hash, walk and entry-count updates.
    always_comb
    begin
        hash_next      = hash_reg;
        count_next     = count_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        key_next       = key_reg;
        type_next      = type_reg;
        setval_next    = setval_reg;
        addr_next      = addr_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        case (state_reg)
            HFT_IDLE:
            begin
                if (accept)
                begin
                    if (item.name_last)
                    begin
                        hash_next   = FNV_BASIS;
                        key_next    = step_hash;
                        type_next   = item.req_type;
                        setval_next = item.set_value;
                        addr_next   = '0;
                        hit_next    = 1'b0;
                    end
                    else
                    begin
                        hash_next = step_hash;
                    end
                end
            end
            HFT_SCAN:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_val_next = rd_val;
                end
                else if (issue)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = addr_reg[IDX_W-1:0];
                    addr_next      = addr_reg + 1'b1;
                end
            end
            HFT_RESP:
            begin
                if ((type_reg == REQ_SET) && !hit_reg && has_room)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                hash_next = hash_reg;
            end
        endcase
    end

    // Outputs: handshake, memory write-back and the result item.
    always_comb
    begin
        busy              = (state_reg != HFT_IDLE);
        done              = (state_reg == HFT_RESP);
        wr_addr           = hit_reg ? hit_idx_reg : count_reg[IDX_W-1:0];
        wr.key_we         = 1'b0;
        wr.val_we         = 1'b0;
        wr.key            = key_reg;
        wr.val            = setval_reg;
        result.name_hash  = key_reg;
        result.flag_value = 1'b0;
        result.op_status  = ST_GET_MISS;
        if (type_reg == REQ_GET)
        begin
            if (hit_reg)
            begin
                result.flag_value = hit_val_reg;
                result.op_status  = ST_GET_HIT;
            end
        end
        else if (hit_reg)
        begin
            result.flag_value = setval_reg;
            result.op_status  = ST_SET_UPD;
            wr.val_we         = done;
        end
        else if (has_room)
        begin
            result.flag_value = setval_reg;
            result.op_status  = ST_SET_INS;
            wr.key_we         = done;
            wr.val_we         = done;
        end
        else
        begin
            result.op_status = ST_SET_FULL;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= HFT_IDLE;
            hash_reg      <= FNV_BASIS;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        type_reg    <= type_next;
        setval_reg  <= setval_next;
        addr_reg    <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_val_reg <= hit_val_next;
    end

endmodule

[hdl/hft_table.sv]
// Entry memories of the flag table: hash keys and boolean values, one read and one write port.
`timescale 1ns / 1ps

module hft_table
    import hft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_key,
    output logic             rd_val,
    input  logic [IDX_W-1:0] wr_addr,
    input  hft_wr_t          wr
);

    logic [31:0] key_mem [TABLE_ENTRIES];
    logic        val_mem [TABLE_ENTRIES];
    logic [31:0] rd_key_reg;
    logic        rd_val_reg;

    // Key memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= wr.key;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    // Value memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (wr.val_we)
        begin
            val_mem[wr_addr] <= wr.val;
        end
        if (rd_en)
        begin
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule
